// ----- rtl/core/mds_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes, types and helpers for the motion sequencer.
package mds_pkg;

  localparam int TICK_BITS = 24;
  localparam int DPT_W     = 24;
  localparam int SUM_W     = TICK_BITS + 1;
  localparam int DIST_W    = TICK_BITS + DPT_W;
  localparam int GOAL_W    = 32;
  localparam int TARGET_W  = 18;
  localparam int DUTY_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  // Item kinds.
  localparam logic [1:0] MODE_CMD    = 2'd0;
  localparam logic [1:0] MODE_EDGE   = 2'd1;
  localparam logic [1:0] MODE_UPDATE = 2'd2;

  // Motion kinds, shared with the command direction field.
  localparam logic [2:0] KIND_FWD   = 3'd0;
  localparam logic [2:0] KIND_REV   = 3'd1;
  localparam logic [2:0] KIND_LEFT  = 3'd2;
  localparam logic [2:0] KIND_RIGHT = 3'd3;
  localparam logic [2:0] KIND_STOP  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POWER_STEP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_TICK   = 2'd2;

  localparam logic [7:0]  POWER_STEP_RST = 8'd5;
  localparam logic [15:0] INTERVAL_RST   = 16'd100;
  localparam logic [DPT_W-1:0] DPT_RST   = 24'd65536;
  localparam logic [7:0]  POWER_RST      = 8'd128;

  typedef struct packed {
    logic [DUTY_W-1:0] lf;
    logic [DUTY_W-1:0] lb;
    logic [DUTY_W-1:0] rf;
    logic [DUTY_W-1:0] rb;
  } duties_t;

  function automatic duties_t drive_duties(input logic [2:0] kind,
                                           input logic [7:0] lp,
                                           input logic [7:0] rp);
    duties_t d;
    d = '0;
    case (kind)
      KIND_FWD: begin
        d.lf = lp;
        d.rf = rp;
      end
      KIND_REV: begin
        d.lb = lp;
        d.rb = rp;
      end
      KIND_LEFT: begin
        d.lb = lp;
        d.rf = rp;
      end
      KIND_RIGHT: begin
        d.lf = lp;
        d.rb = rp;
      end
      default: d = '0;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] clamp_power(input logic signed [9:0] p);
    logic [7:0] r;
    if (p < 10'sd0) begin
      r = 8'd0;
    end else if (p > 10'sd255) begin
      r = 8'd255;
    end else begin
      r = p[7:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/mds_item_if.sv -----
`timescale 1ns / 1ps
// Input item channel: command, encoder edge or update step.
interface mds_item_if;
  import mds_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [2:0]         cmd_dir;
  logic [15:0]        cmd_target;
  logic               edge_side;
  logic signed [15:0] yaw;
  logic [31:0]        now_ms;

  modport source (output valid, mode, cmd_dir, cmd_target, edge_side, yaw, now_ms,
                  input ready);
  modport sink (input valid, mode, cmd_dir, cmd_target, edge_side, yaw, now_ms,
                output ready);
endinterface

// ----- rtl/core/mds_result_if.sv -----
`timescale 1ns / 1ps
// Result channel: drive duties and the motion finished flag.
interface mds_result_if;
  import mds_pkg::*;

  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] left_fwd_duty;
  logic [DUTY_W-1:0] left_bwd_duty;
  logic [DUTY_W-1:0] right_fwd_duty;
  logic [DUTY_W-1:0] right_bwd_duty;
  logic              done_res;

  modport source (output valid, left_fwd_duty, left_bwd_duty, right_fwd_duty,
                  right_bwd_duty, done_res, input ready);
  modport sink (input valid, left_fwd_duty, left_bwd_duty, right_fwd_duty,
                right_bwd_duty, done_res, output ready);
endinterface

// ----- rtl/core/mds_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
interface mds_cfg_if;
  import mds_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/differential_drive_motion_sequencer.sv -----
`timescale 1ns / 1ps
// Top level of the two-wheel motion sequencer.
//
// Every accepted item (command, encoder edge or update step) produces exactly
// one result beat, registered and shown the cycle after acceptance; a new item
// is taken every cycle as long as the result register is empty or being
// drained. The straight-run distance product (average ticks times
// distance_per_tick) is kept in a register refreshed every cycle from the next
// tick sum, so the update step only compares against it. Configuration writes
// are taken at any time.
module differential_drive_motion_sequencer (
  input  logic clk,
  input  logic rst,
  mds_cfg_if.sink      cfg,
  mds_item_if.sink     item,
  mds_result_if.source result
);
  import mds_pkg::*;

  // Configuration registers.
  logic [7:0]       power_step, power_step_next;
  logic [15:0]      update_interval_ms, update_interval_ms_next;
  logic [DPT_W-1:0] distance_per_tick, distance_per_tick_next;

  // Motion state.
  logic [2:0]                 motion_kind, motion_kind_next;
  logic signed [TARGET_W-1:0] motion_target, motion_target_next;
  logic                       finished, finished_next;
  logic [TICK_BITS-1:0]       left_ticks, left_ticks_next;
  logic [TICK_BITS-1:0]       right_ticks, right_ticks_next;
  logic [TICK_BITS-1:0]       left_ticks_seen, left_ticks_seen_next;
  logic [TICK_BITS-1:0]       right_ticks_seen, right_ticks_seen_next;
  logic [SUM_W-1:0]           tick_sum, tick_sum_next;
  logic [DIST_W-1:0]          travel;
  logic [7:0]                 left_power, left_power_next;
  logic [7:0]                 right_power, right_power_next;
  logic [31:0]                last_balance_ms, last_balance_ms_next;
  duties_t                    duties, duties_next;

  // Result register.
  logic    out_valid, out_valid_next;
  duties_t out_duties;
  logic    out_done;

  logic                       accept;
  logic [2:0]                 dir;
  logic signed [TARGET_W-1:0] yaw_ext;
  logic signed [TARGET_W-1:0] cmd_target_ext;
  logic [GOAL_W-1:0]          goal;
  logic                       reached;
  logic [31:0]                elapsed;
  logic [TICK_BITS-1:0]       dl, dr;
  logic signed [9:0]          lp_up, lp_down, rp_up, rp_down;
  logic [7:0]                 lp_bal, rp_bal;

  assign accept     = item.valid && item.ready;
  assign item.ready = !out_valid || result.ready;
  assign cfg.ready  = 1'b1;

  assign yaw_ext        = TARGET_W'(item.yaw);
  assign cmd_target_ext = $signed({{(TARGET_W - 16){1'b0}}, item.cmd_target});
  assign dir            = (item.cmd_dir > KIND_STOP) ? KIND_STOP : item.cmd_dir;
  assign goal           = {motion_target[15:0], 16'd0};
  assign reached        = travel >= DIST_W'(goal);
  assign elapsed        = item.now_ms - last_balance_ms;

  // Ticks never fall below their seen counts, so these differences are exact.
  assign dl      = left_ticks - left_ticks_seen;
  assign dr      = right_ticks - right_ticks_seen;
  assign lp_up   = $signed({2'b00, left_power}) + $signed({2'b00, power_step});
  assign lp_down = $signed({2'b00, left_power}) - $signed({2'b00, power_step});
  assign rp_up   = $signed({2'b00, right_power}) + $signed({2'b00, power_step});
  assign rp_down = $signed({2'b00, right_power}) - $signed({2'b00, power_step});

  always_comb begin
    if (dl > dr) begin
      lp_bal = clamp_power(lp_down);
      rp_bal = clamp_power(rp_up);
    end else if (dl < dr) begin
      lp_bal = clamp_power(lp_up);
      rp_bal = clamp_power(rp_down);
    end else begin
      lp_bal = left_power;
      rp_bal = right_power;
    end
  end

  always_comb begin
    power_step_next         = power_step;
    update_interval_ms_next = update_interval_ms;
    distance_per_tick_next  = distance_per_tick;
    if (cfg.valid) begin
      case (cfg.index)
        REG_POWER_STEP:      power_step_next         = cfg.data[7:0];
        REG_UPDATE_INTERVAL: update_interval_ms_next = cfg.data[15:0];
        REG_DIST_PER_TICK:   distance_per_tick_next  = cfg.data[DPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    motion_kind_next      = motion_kind;
    motion_target_next    = motion_target;
    finished_next         = finished;
    left_ticks_next       = left_ticks;
    right_ticks_next      = right_ticks;
    left_ticks_seen_next  = left_ticks_seen;
    right_ticks_seen_next = right_ticks_seen;
    tick_sum_next         = tick_sum;
    left_power_next       = left_power;
    right_power_next      = right_power;
    last_balance_ms_next  = last_balance_ms;
    duties_next           = duties;
    if (accept) begin
      case (item.mode)
        MODE_CMD: begin
          motion_kind_next = dir;
          finished_next    = 1'b0;
          duties_next      = drive_duties(dir, left_power, right_power);
          if (dir == KIND_FWD || dir == KIND_REV) begin
            motion_target_next    = cmd_target_ext;
            left_ticks_next       = '0;
            right_ticks_next      = '0;
            left_ticks_seen_next  = '0;
            right_ticks_seen_next = '0;
            tick_sum_next         = '0;
          end else if (dir == KIND_LEFT) begin
            motion_target_next = yaw_ext - cmd_target_ext;
          end else if (dir == KIND_RIGHT) begin
            motion_target_next = yaw_ext + cmd_target_ext;
          end
        end
        MODE_EDGE: begin
          if (item.edge_side) begin
            if (right_ticks != TICK_MAX) begin
              right_ticks_next = right_ticks + 1'b1;
              tick_sum_next    = tick_sum + 1'b1;
            end
          end else begin
            if (left_ticks != TICK_MAX) begin
              left_ticks_next = left_ticks + 1'b1;
              tick_sum_next   = tick_sum + 1'b1;
            end
          end
        end
        MODE_UPDATE: begin
          case (motion_kind)
            KIND_FWD, KIND_REV: begin
              if (reached) begin
                duties_next   = '0;
                finished_next = 1'b1;
              end else if (elapsed > {16'd0, update_interval_ms}) begin
                left_ticks_seen_next  = left_ticks;
                right_ticks_seen_next = right_ticks;
                left_power_next       = lp_bal;
                right_power_next      = rp_bal;
                duties_next           = drive_duties(motion_kind, lp_bal, rp_bal);
                last_balance_ms_next  = item.now_ms;
              end
            end
            KIND_LEFT: begin
              if (yaw_ext <= motion_target) begin
                duties_next   = '0;
                finished_next = 1'b1;
              end
            end
            KIND_RIGHT: begin
              if (yaw_ext >= motion_target) begin
                duties_next   = '0;
                finished_next = 1'b1;
              end
            end
            default: finished_next = 1'b1;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (result.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_step         <= POWER_STEP_RST;
      update_interval_ms <= INTERVAL_RST;
      distance_per_tick  <= DPT_RST;
      motion_kind        <= KIND_STOP;
      motion_target      <= '0;
      finished           <= 1'b1;
      left_ticks         <= '0;
      right_ticks        <= '0;
      left_ticks_seen    <= '0;
      right_ticks_seen   <= '0;
      tick_sum           <= '0;
      travel             <= '0;
      left_power         <= POWER_RST;
      right_power        <= POWER_RST;
      last_balance_ms    <= '0;
      duties             <= '0;
      out_valid          <= 1'b0;
    end else begin
      power_step         <= power_step_next;
      update_interval_ms <= update_interval_ms_next;
      distance_per_tick  <= distance_per_tick_next;
      motion_kind        <= motion_kind_next;
      motion_target      <= motion_target_next;
      finished           <= finished_next;
      left_ticks         <= left_ticks_next;
      right_ticks        <= right_ticks_next;
      left_ticks_seen    <= left_ticks_seen_next;
      right_ticks_seen   <= right_ticks_seen_next;
      tick_sum           <= tick_sum_next;
      // Distance covered so far, ready for the next update step to compare.
      travel             <= DIST_W'(tick_sum_next[SUM_W-1:1]) *
                            DIST_W'(distance_per_tick_next);
      left_power         <= left_power_next;
      right_power        <= right_power_next;
      last_balance_ms    <= last_balance_ms_next;
      duties             <= duties_next;
      out_valid          <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_duties <= duties_next;
      out_done   <= finished_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.left_fwd_duty  = out_duties.lf;
  assign result.left_bwd_duty  = out_duties.lb;
  assign result.right_fwd_duty = out_duties.rf;
  assign result.right_bwd_duty = out_duties.rb;
  assign result.done_res       = out_done;

  // Every accepted item yields a result beat in the following cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("accepted item produced no result beat");

  // A stalled result beat holds steady until the receiver takes it.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> (result.valid && $stable(out_duties) &&
     $stable(out_done)))
    else $error("stalled result beat changed before it was taken");

  // A straight command restarts the tick counts.
  a_straight_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && item.mode == MODE_CMD && (item.cmd_dir == KIND_FWD ||
     item.cmd_dir == KIND_REV)) |=> (left_ticks == '0 && right_ticks == '0 &&
     tick_sum == '0))
    else $error("straight command did not clear the tick counts");

endmodule

// ----- bench/differential_drive_motion_sequencer_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the two-wheel motion sequencer: directed and random item streams.
module differential_drive_motion_sequencer_test;
  import mds_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] DIR_UNDEFINED = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic SIDE_LEFT = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;
  localparam int HOLD_CYCLES = 200;
  localparam int IDLE_SETTLE = 5;

  typedef struct {
    logic [1:0]         mode;
    logic [2:0]         dir;
    logic [15:0]        target;
    logic               side;
    logic signed [15:0] yaw;
    logic [31:0]        now_ms;
  } motion_item_t;

  typedef struct {
    duties_t duty;
    logic    done;
  } drive_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mds_cfg_if    cfg();
  mds_item_if   item();
  mds_result_if result();

  differential_drive_motion_sequencer dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .item(item),
    .result(result)
  );

  always #5 clk = ~clk;

  // Shadow of the configuration registers.
  logic [7:0]       cfg_power_step = POWER_STEP_RST;
  logic [15:0]      cfg_interval = INTERVAL_RST;
  logic [DPT_W-1:0] cfg_dist_per_tick = DPT_RST;

  // Predicted sequencer state.
  logic [2:0]           sim_kind = KIND_STOP;
  int                   sim_target = 0;
  logic                 sim_finished = 1'b1;
  logic [TICK_BITS-1:0] sim_lticks = '0;
  logic [TICK_BITS-1:0] sim_rticks = '0;
  logic [TICK_BITS-1:0] sim_lseen = '0;
  logic [TICK_BITS-1:0] sim_rseen = '0;
  logic [7:0]           sim_lpower = POWER_RST;
  logic [7:0]           sim_rpower = POWER_RST;
  logic [31:0]          sim_last_ms = '0;
  duties_t              sim_duty = '0;

  motion_item_t pending_items[$];
  drive_view_t  expected_drive[$];

  int item_offers = 0;
  int item_accepts = 0;
  int results_checked = 0;
  int queued_items = 0;
  int settings_used = 1;
  int error_count = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;
  bit sender_eager = 1'b0;
  bit receiver_eager = 1'b0;
  logic [31:0] gen_ms = '0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] saturate_byte(input int p);
    if (p < 0) return 8'd0;
    if (p > 255) return 8'd255;
    return p[7:0];
  endfunction

  function automatic void drive_current();
    sim_duty = '0;
    case (sim_kind)
      KIND_FWD: begin
        sim_duty.lf = sim_lpower;
        sim_duty.rf = sim_rpower;
      end
      KIND_REV: begin
        sim_duty.lb = sim_lpower;
        sim_duty.rb = sim_rpower;
      end
      KIND_LEFT: begin
        sim_duty.lb = sim_lpower;
        sim_duty.rf = sim_rpower;
      end
      KIND_RIGHT: begin
        sim_duty.lf = sim_lpower;
        sim_duty.rb = sim_rpower;
      end
      default: sim_duty = '0;
    endcase
  endfunction

  // Advances the predicted state by one item and returns the drive it shows.
  function automatic drive_view_t step_sequencer(input motion_item_t it);
    drive_view_t view;
    logic [TICK_BITS:0]   tick_sum;
    logic [TICK_BITS-1:0] grew_l;
    logic [TICK_BITS-1:0] grew_r;
    longint unsigned      travelled;
    longint unsigned      goal;
    int                   lp;
    int                   rp;
    case (it.mode)
      MODE_CMD: begin
        sim_kind = (it.dir > KIND_STOP) ? KIND_STOP : it.dir;
        sim_finished = 1'b0;
        if (sim_kind == KIND_FWD || sim_kind == KIND_REV) begin
          sim_target = int'(it.target);
          sim_lticks = '0;
          sim_rticks = '0;
          sim_lseen = '0;
          sim_rseen = '0;
        end else if (sim_kind == KIND_LEFT) begin
          sim_target = int'(it.yaw) - int'(it.target);
        end else if (sim_kind == KIND_RIGHT) begin
          sim_target = int'(it.yaw) + int'(it.target);
        end
        drive_current();
      end
      MODE_EDGE: begin
        if (it.side == SIDE_RIGHT) begin
          if (sim_rticks != TICK_MAX) sim_rticks = sim_rticks + 1'b1;
        end else begin
          if (sim_lticks != TICK_MAX) sim_lticks = sim_lticks + 1'b1;
        end
      end
      MODE_UPDATE: begin
        if (sim_kind == KIND_FWD || sim_kind == KIND_REV) begin
          tick_sum = {1'b0, sim_lticks} + {1'b0, sim_rticks};
          travelled = longint'(tick_sum >> 1) * longint'(cfg_dist_per_tick);
          goal = longint'(sim_target) << 16;
          if (travelled >= goal) begin
            sim_duty = '0;
            sim_finished = 1'b1;
          end else if ((it.now_ms - sim_last_ms) > {16'd0, cfg_interval}) begin
            grew_l = sim_lticks - sim_lseen;
            grew_r = sim_rticks - sim_rseen;
            sim_lseen = sim_lticks;
            sim_rseen = sim_rticks;
            lp = int'(sim_lpower);
            rp = int'(sim_rpower);
            if (grew_l > grew_r) begin
              lp = lp - int'(cfg_power_step);
              rp = rp + int'(cfg_power_step);
            end else if (grew_l < grew_r) begin
              lp = lp + int'(cfg_power_step);
              rp = rp - int'(cfg_power_step);
            end
            sim_lpower = saturate_byte(lp);
            sim_rpower = saturate_byte(rp);
            drive_current();
            sim_last_ms = it.now_ms;
          end
        end else if (sim_kind == KIND_LEFT) begin
          if (int'(it.yaw) <= sim_target) begin
            sim_duty = '0;
            sim_finished = 1'b1;
          end
        end else if (sim_kind == KIND_RIGHT) begin
          if (int'(it.yaw) >= sim_target) begin
            sim_duty = '0;
            sim_finished = 1'b1;
          end
        end else begin
          sim_finished = 1'b1;
        end
      end
      default: ;
    endcase
    view.duty = sim_duty;
    view.done = sim_finished;
    return view;
  endfunction

  // Result checking and prediction, both on the rising edge.
  always @(posedge clk) begin : watch_channels
    motion_item_t taken;
    drive_view_t  want;
    if (!rst) begin
      if (result.valid && result.ready) begin
        if (expected_drive.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with nothing expected", results_checked));
        end else begin
          want = expected_drive.pop_front();
          if (result.left_fwd_duty !== want.duty.lf)
            report_mismatch($sformatf("beat %0d left_fwd_duty %0d, expected %0d",
                                      results_checked, result.left_fwd_duty, want.duty.lf));
          if (result.left_bwd_duty !== want.duty.lb)
            report_mismatch($sformatf("beat %0d left_bwd_duty %0d, expected %0d",
                                      results_checked, result.left_bwd_duty, want.duty.lb));
          if (result.right_fwd_duty !== want.duty.rf)
            report_mismatch($sformatf("beat %0d right_fwd_duty %0d, expected %0d",
                                      results_checked, result.right_fwd_duty, want.duty.rf));
          if (result.right_bwd_duty !== want.duty.rb)
            report_mismatch($sformatf("beat %0d right_bwd_duty %0d, expected %0d",
                                      results_checked, result.right_bwd_duty, want.duty.rb));
          if (result.done_res !== want.done)
            report_mismatch($sformatf("beat %0d done_res %0b, expected %0b",
                                      results_checked, result.done_res, want.done));
        end
        results_checked++;
      end
      if (item.valid && item.ready) begin
        taken.mode = item.mode;
        taken.dir = item.cmd_dir;
        taken.target = item.cmd_target;
        taken.side = item.edge_side;
        taken.yaw = item.yaw;
        taken.now_ms = item.now_ms;
        expected_drive.push_back(step_sequencer(taken));
        item_accepts++;
      end
    end
  end

  // Item driver: presents the next pending beat once the current one is taken.
  always @(negedge clk) begin : feed_items
    motion_item_t nxt;
    if (!rst) begin
      if (!item.valid || item_accepts == item_offers) begin
        if (send_gap > 0) begin
          send_gap--;
          item.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          item.mode <= nxt.mode;
          item.cmd_dir <= nxt.dir;
          item.cmd_target <= nxt.target;
          item.edge_side <= nxt.side;
          item.yaw <= nxt.yaw;
          item.now_ms <= nxt.now_ms;
          item.valid <= 1'b1;
          item_offers++;
          send_gap = sender_eager ? 0 : pick_gap();
        end else begin
          item.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver with random stalls and one long hold-off on request.
  always @(negedge clk) begin : drain_results
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      result.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
      if (!receiver_eager && $urandom_range(0, 3) == 0) recv_gap = pick_gap();
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    case (idx)
      REG_POWER_STEP:      cfg_power_step = val[7:0];
      REG_UPDATE_INTERVAL: cfg_interval = val[15:0];
      REG_DIST_PER_TICK:   cfg_dist_per_tick = val[DPT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [7:0] step, input logic [15:0] interval,
                               input logic [DPT_W-1:0] dpt);
    write_register(REG_POWER_STEP, {16'd0, step});
    write_register(REG_UPDATE_INTERVAL, {8'd0, interval});
    write_register(REG_DIST_PER_TICK, dpt);
    repeat (3) @(posedge clk);
    settings_used++;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || item_offers != item_accepts ||
           expected_drive.size() != 0)
      @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic push_item(input logic [1:0] m, input logic [2:0] d, input logic [15:0] tg,
                           input logic sd, input logic [15:0] y, input logic [31:0] ms);
    motion_item_t it;
    it.mode = m;
    it.dir = d;
    it.target = tg;
    it.side = sd;
    it.yaw = y;
    it.now_ms = ms;
    pending_items.push_back(it);
    queued_items++;
  endtask

  // Fields that an item kind ignores carry random values.
  task automatic push_command(input logic [2:0] d, input logic [15:0] tg, input logic [15:0] y);
    push_item(MODE_CMD, d, tg, 1'($urandom_range(0, 1)), y, $urandom);
  endtask

  task automatic push_edge(input logic sd);
    push_item(MODE_EDGE, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)), sd,
              16'($urandom_range(0, 65535)), $urandom);
  endtask

  task automatic push_update(input logic [15:0] y, input logic [31:0] ms);
    push_item(MODE_UPDATE, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
              1'($urandom_range(0, 1)), y, ms);
  endtask

  function automatic logic [15:0] rand_yaw();
    int y;
    y = int'($urandom_range(0, 36000)) - 18000;
    return y[15:0];
  endfunction

  task automatic advance_clock();
    if ($urandom_range(0, 9) == 0) gen_ms = $urandom;
    else gen_ms = gen_ms + $urandom_range(0, 2 * int'(cfg_interval) + 2);
  endtask

  // A straight run whose target is usually within reach of the edges that follow it.
  task automatic gen_straight_run();
    int              ticks_goal;
    int              steps;
    int              left_bias;
    longint unsigned tgt;
    ticks_goal = $urandom_range(0, 24);
    tgt = (longint'(ticks_goal) * longint'(cfg_dist_per_tick)) >> 16;
    if ($urandom_range(0, 9) == 0) tgt = 64'($urandom_range(0, 65535));
    if (tgt > 65535) tgt = 65535;
    push_command($urandom_range(0, 1) ? KIND_REV : KIND_FWD, tgt[15:0], rand_yaw());
    steps = $urandom_range(10, 60);
    left_bias = $urandom_range(15, 85);
    repeat (steps) begin
      if ($urandom_range(0, 99) < 65) begin
        push_edge(($urandom_range(0, 99) < left_bias) ? SIDE_LEFT : SIDE_RIGHT);
      end else begin
        advance_clock();
        push_update(rand_yaw(), gen_ms);
      end
    end
  endtask

  // A turn followed by yaw samples drifting toward the target.
  task automatic gen_turn();
    int y;
    int angle;
    int stride;
    int steps;
    bit go_left;
    go_left = 1'($urandom_range(0, 1));
    y = int'($urandom_range(0, 36000)) - 18000;
    angle = $urandom_range(0, 3000);
    if ($urandom_range(0, 9) == 0) angle = 0;
    else if ($urandom_range(0, 19) == 0) angle = 65535;
    push_command(go_left ? KIND_LEFT : KIND_RIGHT, angle[15:0], y[15:0]);
    stride = $urandom_range(50, 800);
    steps = $urandom_range(3, 15);
    repeat (steps) begin
      if ($urandom_range(0, 4) == 0) stride = -stride;
      y = go_left ? y - int'($urandom_range(0, stride < 0 ? -stride : stride))
                  : y + int'($urandom_range(0, stride < 0 ? -stride : stride));
      if (stride < 0) stride = -stride;
      if (y > 18000) y = 18000;
      if (y < -18000) y = -18000;
      if ($urandom_range(0, 5) == 0) push_edge(1'($urandom_range(0, 1)));
      advance_clock();
      push_update(y[15:0], gen_ms);
    end
  endtask

  task automatic gen_stop();
    push_command($urandom_range(0, 1) ? KIND_STOP : 3'($urandom_range(5, 7)),
                 16'($urandom_range(0, 65535)), rand_yaw());
    repeat ($urandom_range(1, 3)) begin
      advance_clock();
      push_update(rand_yaw(), gen_ms);
    end
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 3))
      push_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                16'($urandom_range(0, 65535)), $urandom);
  endtask

  task automatic gen_random(input int count);
    int start;
    int pick;
    start = queued_items;
    while (queued_items - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) gen_straight_run();
      else if (pick < 75) gen_turn();
      else if (pick < 85) gen_stop();
      else gen_noise();
    end
  endtask

  task automatic gen_directed();
    push_update(rand_yaw(), 32'd10);
    push_item(MODE_UNUSED, KIND_FWD, 16'd77, SIDE_RIGHT, 16'd5, 32'd12);
    // Unequal wheel growth, one balancing step, then the distance is reached.
    push_command(KIND_FWD, 16'd2, rand_yaw());
    push_edge(SIDE_LEFT);
    push_edge(SIDE_LEFT);
    push_edge(SIDE_RIGHT);
    push_update(rand_yaw(), 32'd50);
    push_update(rand_yaw(), 32'd200);
    push_edge(SIDE_RIGHT);
    push_edge(SIDE_RIGHT);
    push_update(rand_yaw(), 32'd210);
    push_update(rand_yaw(), 32'd5000);
    push_command(KIND_REV, 16'd0, rand_yaw());
    push_update(rand_yaw(), 32'd5001);
    push_command(KIND_LEFT, 16'd1000, 16'd0);
    push_update(-16'sd500, 32'd5002);
    push_update(-16'sd1000, 32'd5003);
    push_command(KIND_RIGHT, 16'hFFFF, 16'sd18000);
    push_update(16'sd18000, 32'd5004);
    push_command(KIND_RIGHT, 16'd0, -16'sd18000);
    push_update(-16'sd18000, 32'd5005);
    push_command(DIR_UNDEFINED, 16'h5A5A, rand_yaw());
    push_update(rand_yaw(), 32'd5006);
    push_command(KIND_FWD, 16'hFFFF, -16'sd18000);
    push_update(rand_yaw(), 32'hFFFF_FFFF);
    push_command(KIND_STOP, 16'd0, rand_yaw());
  endtask

  initial begin
    cfg.valid = 1'b0;
    cfg.index = REG_POWER_STEP;
    cfg.data = '0;
    item.valid = 1'b0;
    item.mode = MODE_CMD;
    item.cmd_dir = KIND_STOP;
    item.cmd_target = '0;
    item.edge_side = SIDE_LEFT;
    item.yaw = '0;
    item.now_ms = '0;
    result.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // Reset values of the registers.
    gen_directed();
    wait_idle();

    // Extremes (largest power step and distance per tick, zero interval), with both sides streaming back to back.
    sender_eager = 1'b1;
    receiver_eager = 1'b1;
    load_settings(8'd255, 16'd0, {DPT_W{1'b1}});
    gen_ms = '0;
    gen_random(120);
    wait_idle();
    sender_eager = 1'b0;
    receiver_eager = 1'b0;

    // Opposite extremes (zero power step and distance per tick, largest interval).
    load_settings(8'd0, 16'hFFFF, '0);
    gen_random(80);
    wait_idle();

    // Moderate values, plus a long result hold-off that backs up the input.
    write_register(REG_UNUSED, CFG_DATA_W'($urandom));
    load_settings(8'($urandom_range(1, 20)), 16'($urandom_range(0, 500)),
                  DPT_W'($urandom_range(1 << 14, 1 << 18)));
    gen_random(150);
    hold_request = 1'b1;
    wait_idle();

    load_settings(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), DPT_RST);
    gen_random(150);
    wait_idle();

    repeat (IDLE_SETTLE) @(posedge clk);
    if (expected_drive.size() != 0)
      report_mismatch($sformatf("%0d expected beats never arrived", expected_drive.size()));
    $display("Run covered %0d items and %0d checked result beats over %0d register settings,",
             item_accepts, results_checked, settings_used);
    $display("with directed corner cases, random runs and turns, and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mds_pkg.sv
rtl/core/mds_item_if.sv
rtl/core/mds_result_if.sv
rtl/core/mds_cfg_if.sv
rtl/core/differential_drive_motion_sequencer.sv
bench/differential_drive_motion_sequencer_test.sv
